[sv/alt_pkg.sv]
package alt_pkg;

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int XID_W  = 32;
    localparam int HOST_W = 8;

    localparam logic [1:0] ACT_DISCOVER = 2'd0;
    localparam logic [1:0] ACT_REQUEST  = 2'd1;
    localparam logic [1:0] ACT_LOOKUP   = 2'd2;

    localparam logic CFG_SERVER_ADDRESS = 1'b0;
    localparam logic CFG_SERVER_VALID   = 1'b1;

    localparam logic [HOST_W-1:0] HOST_LIMIT = 8'd255;
    localparam logic [HOST_W-1:0] HOST_FAIL  = 8'd254;

    typedef struct packed {
        logic [1:0]       action;
        logic [MAC_W-1:0] mac;
        logic [XID_W-1:0] xid;
        logic [IP_W-1:0]  client_ip;
        logic [IP_W-1:0]  your_ip;
    } t_item;

    typedef struct packed {
        logic            ok;
        logic [IP_W-1:0] ip_address;
        logic            recorded;
    } t_result;

    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  addr;
        logic [XID_W-1:0] xid;
    } t_entry;

endpackage

[sv/alt_ram.sv]
module alt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/address_lease_table.sv]
// Sequence: request and lookup read then compare each valid entry and skip each free entry
// scanned (S_RD, S_CMP), then register the result beat; refused and unknown commands answer next cycle.
// Discover repeats that scan for each candidate host already leased, then decides in S_DECIDE,
// walks the valid bits in S_FREE and does a read-modify-write of the slot in S_FILL.
// Flow: one item at a time; busy is high until the result beat of an accepted item; lease RAM read port bound.
// Synchronous active-low reset clears all valid bits and config and sets the host counter to FIRST_HOST at once.
// The result beat is a one-cycle strobe on o_done; the receiver cannot stall.
module address_lease_table
    import alt_pkg::*;
#(
    parameter int CLIENTS    = 16,
    parameter int FIRST_HOST = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_item         i_item,
    output logic          o_done,
    output t_result       o_result,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_DECIDE,
        S_FREE,
        S_FILL
    } t_state;

    t_state              r_state;
    t_item               r_item;
    logic [IP_W-1:0]     r_req;
    logic [HOST_W-1:0]   r_cand;
    logic [HOST_W-1:0]   r_next_host;
    logic [IW-1:0]       r_idx;
    logic [CLIENTS-1:0]  r_valid;
    logic [IP_W-1:0]     r_srv_addr;
    logic                r_srv_valid;

    t_entry              ram_rdata;
    t_entry              ram_wdata;
    logic                ram_we;

    logic [IP_W-1:0]     cand_addr;
    logic [HOST_W-1:0]   nh_inc;
    logic                idx_last;
    logic                hit;
    logic [IP_W-1:0]     item_req;

    assign cand_addr = {r_srv_addr[IP_W-1:HOST_W], r_cand};
    assign nh_inc    = (r_next_host == HOST_LIMIT) ? r_next_host : r_next_host + 8'd1;
    assign idx_last  = (r_idx == IW'(CLIENTS - 1));
    assign hit       = (r_item.action == ACT_DISCOVER) ? (ram_rdata.addr == cand_addr)
                                                       : (ram_rdata.mac == r_item.mac);
    assign item_req  = (i_item.client_ip[31:24] == 8'd0 && i_item.client_ip[7:0] == 8'd0)
                       ? i_item.your_ip : i_item.client_ip;

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = '{mac: r_item.mac, addr: r_req, xid: r_item.xid};
        case (r_state)
            S_CMP: begin
                ram_we = hit && (r_item.action == ACT_REQUEST);
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = '{mac: r_item.mac, addr: cand_addr, xid: ram_rdata.xid};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    alt_ram #(
        .WIDTH (EW),
        .DEPTH (CLIENTS)
    ) u_lease_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srv_addr  <= '0;
            r_srv_valid <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SERVER_ADDRESS: r_srv_addr  <= i_cfg_data;
                CFG_SERVER_VALID:   r_srv_valid <= i_cfg_data[0];
                default:            r_srv_valid <= r_srv_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            busy        <= 1'b0;
            o_done      <= 1'b0;
            o_result    <= '0;
            r_valid     <= '0;
            r_next_host <= 8'(FIRST_HOST);
            r_idx       <= '0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item <= i_item;
                        r_req  <= item_req;
                        r_cand <= r_next_host;
                        r_idx  <= '0;
                        o_result <= '0;
                        case (i_item.action)
                            ACT_DISCOVER: begin
                                if (r_srv_valid) begin
                                    r_next_host <= nh_inc;
                                    r_state <= (nh_inc < HOST_LIMIT) ? S_RD : S_DECIDE;
                                    busy    <= 1'b1;
                                end else begin
                                    o_done <= 1'b1;
                                end
                            end
                            ACT_REQUEST: begin
                                if (r_srv_valid) begin
                                    r_state <= S_RD;
                                    busy    <= 1'b1;
                                end else begin
                                    o_done <= 1'b1;
                                end
                            end
                            ACT_LOOKUP: begin
                                r_state <= S_RD;
                                busy    <= 1'b1;
                            end
                            default: begin
                                o_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    if (r_valid[r_idx]) begin
                        r_state <= S_CMP;
                    end else if (!idx_last) begin
                        r_idx <= r_idx + IW'(1);
                    end else if (r_item.action == ACT_DISCOVER) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_state  <= S_IDLE;
                        busy     <= 1'b0;
                        o_done   <= 1'b1;
                        o_result <= '{ok: (r_item.action == ACT_REQUEST),
                                      ip_address: (r_item.action == ACT_REQUEST) ? r_req : '0,
                                      recorded: 1'b0};
                    end
                end
                S_CMP: begin
                    if (hit) begin
                        case (r_item.action)
                            ACT_DISCOVER: begin
                                r_next_host <= nh_inc;
                                r_cand      <= nh_inc;
                                r_idx       <= '0;
                                r_state     <= (nh_inc < HOST_LIMIT) ? S_RD : S_DECIDE;
                            end
                            ACT_REQUEST: begin
                                r_state  <= S_IDLE;
                                busy     <= 1'b0;
                                o_done   <= 1'b1;
                                o_result <= '{ok: 1'b1, ip_address: r_req, recorded: 1'b1};
                            end
                            default: begin
                                r_state  <= S_IDLE;
                                busy     <= 1'b0;
                                o_done   <= 1'b1;
                                o_result <= '{ok: 1'b1, ip_address: ram_rdata.addr,
                                              recorded: 1'b0};
                            end
                        endcase
                    end else if (!idx_last) begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_RD;
                    end else if (r_item.action == ACT_DISCOVER) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_state  <= S_IDLE;
                        busy     <= 1'b0;
                        o_done   <= 1'b1;
                        o_result <= '{ok: (r_item.action == ACT_REQUEST),
                                      ip_address: (r_item.action == ACT_REQUEST) ? r_req : '0,
                                      recorded: 1'b0};
                    end
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    if (r_next_host >= HOST_FAIL) begin
                        r_state  <= S_IDLE;
                        busy     <= 1'b0;
                        o_done   <= 1'b1;
                        o_result <= '0;
                    end else begin
                        r_state <= S_FREE;
                    end
                end
                S_FREE: begin
                    if (!r_valid[r_idx]) begin
                        r_state <= S_FILL;
                    end else if (!idx_last) begin
                        r_idx <= r_idx + IW'(1);
                    end else begin
                        r_state  <= S_IDLE;
                        busy     <= 1'b0;
                        o_done   <= 1'b1;
                        o_result <= '{ok: 1'b1, ip_address: cand_addr, recorded: 1'b0};
                    end
                end
                S_FILL: begin
                    r_valid[r_idx] <= 1'b1;
                    r_state  <= S_IDLE;
                    busy     <= 1'b0;
                    o_done   <= 1'b1;
                    o_result <= '{ok: 1'b1, ip_address: cand_addr, recorded: 1'b1};
                end
                default: begin
                    r_state <= S_IDLE;
                    busy    <= 1'b0;
                end
            endcase
        end
    end

endmodule

[test/lease_checker.sv]
module lease_checker
    import alt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_item       i_item,
    input  logic        i_done,
    input  t_result     i_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int                LEASES     = 16;
    localparam logic [HOST_W-1:0] FIRST_HOST = 8'd20;

    logic [IP_W-1:0]   srv_addr;
    logic              srv_valid;
    logic              lease_valid [LEASES];
    logic [MAC_W-1:0]  lease_mac   [LEASES];
    logic [IP_W-1:0]   lease_ip    [LEASES];
    logic [XID_W-1:0]  lease_xid   [LEASES];
    logic [HOST_W-1:0] next_host;
    t_result           answers [$];
    int                fails = 0;

    function automatic logic [IP_W-1:0] host_ip(input logic [HOST_W-1:0] host);
        return {srv_addr[31:8], host};
    endfunction

    function automatic logic leased(input logic [IP_W-1:0] ip);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < LEASES; i++) begin
            if (lease_valid[i] && lease_ip[i] == ip) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic int slot_of_mac(input logic [MAC_W-1:0] mac);
        int slot;
        slot = -1;
        for (int i = LEASES - 1; i >= 0; i--) begin
            if (lease_valid[i] && lease_mac[i] == mac) begin
                slot = i;
            end
        end
        return slot;
    endfunction

    // updates the lease state and returns the answer to one command
    function automatic t_result lease_answer(input t_item it);
        t_result           r;
        logic [HOST_W-1:0] cand;
        logic [IP_W-1:0]   req;
        int                slot;
        r = '0;
        case (it.action)
            ACT_DISCOVER: begin
                if (srv_valid) begin
                    cand = next_host;
                    if (next_host < HOST_LIMIT) begin
                        next_host = next_host + 8'd1;
                    end
                    while (next_host < HOST_LIMIT && leased(host_ip(cand))) begin
                        next_host = next_host + 8'd1;
                        cand      = next_host;
                    end
                    if (next_host < HOST_FAIL) begin
                        r.ok         = 1'b1;
                        r.ip_address = host_ip(cand);
                        for (int i = 0; i < LEASES; i++) begin
                            if (!r.recorded && !lease_valid[i]) begin
                                lease_valid[i] = 1'b1;
                                lease_ip[i]    = host_ip(cand);
                                lease_mac[i]   = it.mac;
                                r.recorded     = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_REQUEST: begin
                if (srv_valid) begin
                    req = it.client_ip;
                    if (it.client_ip[31:24] == 8'd0 && it.client_ip[7:0] == 8'd0) begin
                        req = it.your_ip;
                    end
                    slot = slot_of_mac(it.mac);
                    if (slot >= 0) begin
                        lease_xid[slot] = it.xid;
                        lease_ip[slot]  = req;
                        r.recorded      = 1'b1;
                    end
                    r.ok         = 1'b1;
                    r.ip_address = req;
                end
            end
            ACT_LOOKUP: begin
                slot = slot_of_mac(it.mac);
                if (slot >= 0) begin
                    r.ok         = 1'b1;
                    r.ip_address = lease_ip[slot];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < LEASES; i++) begin
                lease_valid[i] = 1'b0;
                lease_mac[i]   = '0;
                lease_ip[i]    = '0;
                lease_xid[i]   = '0;
            end
            next_host = FIRST_HOST;
            srv_addr  = '0;
            srv_valid = 1'b0;
            answers.delete();
        end else begin
            if (i_done) begin
                if (answers.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result beat ok=%0b ip=%h recorded=%0b",
                             $time, i_result.ok, i_result.ip_address, i_result.recorded);
                end else begin
                    want = answers.pop_front();
                    if (i_result !== want) begin
                        fails++;
                        $display("%0t: expected ok=%0b ip=%h rec=%0b, got ok=%0b ip=%h rec=%0b",
                                 $time, want.ok, want.ip_address, want.recorded,
                                 i_result.ok, i_result.ip_address, i_result.recorded);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SERVER_ADDRESS) begin
                    srv_addr = i_cfg_data;
                end else begin
                    srv_valid = i_cfg_data[0];
                end
            end
            if (i_start && !i_busy) begin
                answers.push_back(lease_answer(i_item));
            end
        end
        o_fail_count <= fails;
        o_pending    <= answers.size();
    end

endmodule

[test/tb_address_lease_table.sv]
module tb_address_lease_table;
    import alt_pkg::*;

    localparam logic [1:0]      ACT_UNKNOWN = 2'd3;
    localparam logic [IP_W-1:0] HOME_NET    = 32'hC0A8_0101;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    t_item       item;
    logic        done;
    t_result     result;
    logic        cfg_we;
    logic        cfg_idx;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;

    int               idle_pct = 0;
    logic [IP_W-1:0]  srv_net  = '0;
    logic [MAC_W-1:0] mac_pool [8];

    always #4 clk = ~clk;

    address_lease_table dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lease_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_done       (done),
        .i_result     (result),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_item item_of(input logic [1:0] act, input logic [MAC_W-1:0] mac,
                                      input logic [XID_W-1:0] xid,
                                      input logic [IP_W-1:0] cip, input logic [IP_W-1:0] yip);
        t_item it;
        it.action    = act;
        it.mac       = mac;
        it.xid       = xid;
        it.client_ip = cip;
        it.your_ip   = yip;
        return it;
    endfunction

    function automatic logic [MAC_W-1:0] any_mac();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[MAC_W-1:0];
    endfunction

    function automatic t_item rand_item();
        t_item       it;
        int unsigned pick;
        logic [15:0] mid;
        pick = $urandom_range(99);
        if (pick < 24) begin
            it.action = ACT_DISCOVER;
        end else if (pick < 60) begin
            it.action = ACT_REQUEST;
        end else if (pick < 95) begin
            it.action = ACT_LOOKUP;
        end else begin
            it.action = ACT_UNKNOWN;
        end
        it.mac = ($urandom_range(99) < 80) ? mac_pool[$urandom_range(7)] : any_mac();
        it.xid = $urandom;
        pick = $urandom_range(99);
        mid  = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
        if (pick < 35) begin
            it.client_ip = {8'd0, mid, 8'd0};
        end else if (pick < 70) begin
            it.client_ip = {srv_net[31:8], 8'($urandom)};
        end else begin
            it.client_ip = $urandom;
        end
        it.your_ip = ($urandom_range(1) == 0) ? {srv_net[31:8], 8'($urandom)} : $urandom;
        return it;
    endfunction

    task automatic send(input t_item it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SERVER_ADDRESS) begin
            srv_net = data;
        end
    endtask

    task automatic run_phase(input logic [31:0] addr, input logic valid, input int pct,
                             input int count);
        settle();
        write_reg(CFG_SERVER_ADDRESS, addr);
        write_reg(CFG_SERVER_VALID, {31'd0, valid});
        idle_pct = pct;
        repeat (count) send(rand_item());
    endtask

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        item     <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_SERVER_ADDRESS;
        cfg_data <= '0;
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (int i = 2; i < 8; i++) begin
            mac_pool[i] = any_mac();
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no server address yet: discover and request refused
        send(item_of(ACT_DISCOVER, mac_pool[2], '0, '0, '0));
        send(item_of(ACT_REQUEST, mac_pool[2], '1, '1, '1));
        send(item_of(ACT_LOOKUP, mac_pool[2], '0, '0, '0));
        send(item_of(ACT_UNKNOWN, '1, '1, '1, '1));

        settle();
        write_reg(CFG_SERVER_ADDRESS, HOME_NET);
        write_reg(CFG_SERVER_VALID, 32'd1);
        send(item_of(ACT_DISCOVER, mac_pool[2], '0, '0, '0));
        send(item_of(ACT_DISCOVER, mac_pool[1], '1, '1, '1));
        send(item_of(ACT_DISCOVER, mac_pool[0], '0, '0, '0));
        send(item_of(ACT_LOOKUP, mac_pool[2], '0, '0, '0));
        send(item_of(ACT_LOOKUP, 48'h0000_DEAD_0001, '0, '0, '0));
        // fallback to your_ip when octets 0 and 3 are zero
        send(item_of(ACT_REQUEST, mac_pool[2], '1, '0, '1));
        send(item_of(ACT_REQUEST, mac_pool[1], 32'h1234_5678, 32'h00AB_CD00,
                     {HOME_NET[31:8], 8'd99}));
        send(item_of(ACT_REQUEST, mac_pool[0], '0, 32'h0000_0005, '1));
        send(item_of(ACT_REQUEST, mac_pool[0], '0, 32'h0500_0000, '1));
        // park a lease on the next candidate so discover must skip it
        send(item_of(ACT_REQUEST, mac_pool[0], '1, {HOME_NET[31:8], 8'd23}, '0));
        send(item_of(ACT_REQUEST, 48'h1234_5678_9ABC, '1, '1, '0));
        send(item_of(ACT_DISCOVER, mac_pool[3], '0, '0, '0));
        // duplicate MAC: lookup returns the lowest slot
        send(item_of(ACT_DISCOVER, mac_pool[2], '0, '0, '0));
        send(item_of(ACT_LOOKUP, mac_pool[2], '0, '0, '0));
        send(item_of(ACT_LOOKUP, mac_pool[1], '0, '0, '0));
        send(item_of(ACT_UNKNOWN, '0, '0, '0, '0));

        run_phase(HOME_NET, 1'b1, 0, 300);
        run_phase(32'hFFFF_FFFF, 1'b1, 84, 250);
        run_phase(32'h0000_0000, 1'b0, 21, 100);
        run_phase(32'h0000_0000, 1'b1, 21, 250);
        run_phase($urandom, 1'b1, 84, 200);
        run_phase(HOME_NET, 1'b1, 0, 125);

        settle();
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[address_lease_table.f]
sv/alt_pkg.sv
sv/alt_ram.sv
sv/address_lease_table.sv
test/lease_checker.sv
test/tb_address_lease_table.sv
